FILE: rtl/prc_pkg.sv
// Package for the PID rate controller: field widths, codes, limits and the
// structs passed between the controller's modules. No dependencies.
package prc_pkg;

    localparam int ERR_W   = 32;               // Q16.16 error and drive values
    localparam int GAIN_W  = 32;               // Q8.24 gains
    localparam int SUM_W   = 24;               // clamped running error sum
    localparam int DIFF_W  = 33;               // error difference, never wrapped
    localparam int MAG_W   = 42;               // magnitude fed to the multiplier
    localparam int WIDE_W  = MAG_W + 1;        // signed intermediate sums
    localparam int ACC_W   = MAG_W + GAIN_W;   // full product of magnitude and gain
    localparam int FRAC_SH = 24;               // Q8.24 gain fraction bits
    localparam int Q_W     = ACC_W - FRAC_SH;  // product after the gain shift
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic signed [SUM_W-1:0] SUM_LIMIT = 24'sd6553600;   // +100.0
    localparam logic [Q_W-1:0] OUT_POS_MAX = Q_W'(64'd2147483647);
    localparam logic [Q_W-1:0] OUT_NEG_MAX = Q_W'(64'd2147483648);

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [1:0] REG_KP = 2'd0;
    localparam logic [1:0] REG_KI = 2'd1;
    localparam logic [1:0] REG_KD = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_gains;

    // One step of the shared multiplier: low chunk, high chunk, accumulate.
    typedef struct packed {
        logic lo;
        logic hi;
        logic add;
    } t_mul_ctl;

endpackage

FILE: rtl/prc_if.sv
// Handshake channels of the PID rate controller: update/clear items in and
// drive values out. Depends on prc_pkg.
interface prc_in_if;
    import prc_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [ERR_W-1:0]  error_value;

    modport source(output valid, command, error_value, input ready);
    modport sink(input valid, command, error_value, output ready);
endinterface

interface prc_out_if;
    import prc_pkg::*;
    logic              valid;
    logic              ready;
    logic [ERR_W-1:0]  drive_value;

    modport source(output valid, drive_value, input ready);
    modport sink(input valid, drive_value, output ready);
endinterface

FILE: rtl/prc_regs.sv
// APB-style register file holding the three Q8.24 gains.
// Depends on prc_pkg.
module prc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prc_pkg::ADDR_W-1:0]   paddr,
    input  logic [prc_pkg::DATA_W-1:0]   pwdata,
    output logic [prc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output prc_pkg::t_gains              o_gains
);
    import prc_pkg::*;

    t_gains     r_gains;
    logic [1:0] w_index;
    logic       w_write;

    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_gains = r_gains;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (w_write) begin
            unique case (w_index)
                REG_KP:  r_gains.kp <= pwdata;
                REG_KI:  r_gains.ki <= pwdata;
                REG_KD:  r_gains.kd <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_KP:  prdata = r_gains.kp;
            REG_KI:  prdata = r_gains.ki;
            REG_KD:  prdata = r_gains.kd;
            default: prdata = '0;
        endcase
    end

endmodule

FILE: rtl/prc_mul_unit.sv
// Shared multiply-accumulate unit: a 42-bit magnitude times a 32-bit gain in
// two 32x32 passes, result shifted right by 24. Depends on prc_pkg.
module prc_mul_unit (
    input  logic                         i_clk,
    input  prc_pkg::t_mul_ctl            i_ctl,
    input  logic [prc_pkg::MAG_W-1:0]    i_mag,
    input  logic [prc_pkg::GAIN_W-1:0]   i_gain,
    output logic [prc_pkg::Q_W-1:0]      o_q
);
    import prc_pkg::*;

    localparam int HI_W = MAG_W - 32;

    logic [31:0]            w_chunk;
    logic [63:0]            r_prod;
    logic [ACC_W-1:0]       r_acc;

    assign w_chunk = i_ctl.hi ? {{(32-HI_W){1'b0}}, i_mag[MAG_W-1:32]} : i_mag[31:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.lo || i_ctl.hi) begin
            r_prod <= 64'(w_chunk) * 64'(i_gain);
        end
        // The low product lands in the accumulator while the high one is formed.
        if (i_ctl.hi) begin
            r_acc <= ACC_W'(r_prod);
        end else if (i_ctl.add) begin
            r_acc <= r_acc + {r_prod[HI_W+GAIN_W-1:0], 32'b0};
        end
    end

    assign o_q = r_acc[ACC_W-1:FRAC_SH];

endmodule

FILE: rtl/pid_rate_controller.sv
// PID rate controller: clamped integral, derivative and proportional gain.
// An update item's three gain products each pass twice through the one shared
// 32x32 multiplier; no new item is accepted until its result is loaded, and a
// stalled output holds that off. A clear item is taken without leaving idle.
// Synchronous active-low reset clears the gains, the sum, the previous error
// and the sequencer. Depends on prc_pkg, prc_if, prc_regs and prc_mul_unit.
module pid_rate_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    prc_in_if.sink                       i_in,
    prc_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prc_pkg::ADDR_W-1:0]   paddr,
    input  logic [prc_pkg::DATA_W-1:0]   pwdata,
    output logic [prc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import prc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_I_LO  = 4'd1;
    localparam logic [3:0] S_I_HI  = 4'd2;
    localparam logic [3:0] S_I_ADD = 4'd3;
    localparam logic [3:0] S_D_LO  = 4'd4;
    localparam logic [3:0] S_D_HI  = 4'd5;
    localparam logic [3:0] S_D_ADD = 4'd6;
    localparam logic [3:0] S_INNER = 4'd7;
    localparam logic [3:0] S_ABS   = 4'd8;
    localparam logic [3:0] S_K_LO  = 4'd9;
    localparam logic [3:0] S_K_HI  = 4'd10;
    localparam logic [3:0] S_K_ADD = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] neg;
        neg = -v;
        return v[WIDE_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    function automatic logic signed [WIDE_W-1:0] signed_q(input logic [Q_W-1:0] q,
                                                          input logic negative);
        logic signed [WIDE_W-1:0] pos;
        pos = {1'b0, q[MAG_W-1:0]};
        return negative ? -pos : pos;
    endfunction

    t_gains                    w_gains;
    t_mul_ctl                  w_ctl;
    logic [GAIN_W-1:0]         w_gain;
    logic [Q_W-1:0]            w_q;

    logic [3:0]                r_state, n_state;
    logic signed [SUM_W-1:0]   r_err_sum;
    logic signed [ERR_W-1:0]   r_prev;
    logic signed [ERR_W-1:0]   r_e;
    logic signed [DIFF_W-1:0]  r_diff;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_neg_i, r_neg_d, r_neg_k;
    logic signed [WIDE_W-1:0]  r_ip;
    logic signed [WIDE_W-1:0]  r_inner;
    logic                      r_out_valid;
    logic [ERR_W-1:0]          r_drive;

    logic                      w_accept;
    logic signed [ERR_W-1:0]   w_e;
    logic signed [ERR_W:0]     w_sum_raw;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [WIDE_W-1:0]  w_inner;
    logic                      w_load_out;
    logic [ERR_W-1:0]          w_sat_mag;
    logic [ERR_W-1:0]          w_drive;

    prc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (w_gains)
    );

    prc_mul_unit u_mul (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_mag  (r_mag),
        .i_gain (w_gain),
        .o_q    (w_q)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_e        = i_in.error_value;

    // Running sum, clamped to plus or minus 100.0.
    always_comb begin
        w_sum_raw = {{(ERR_W + 1 - SUM_W){r_err_sum[SUM_W-1]}}, r_err_sum} + {w_e[ERR_W-1], w_e};
        if (w_sum_raw > (ERR_W+1)'(SUM_LIMIT)) begin
            w_sum = SUM_LIMIT;
        end else if (w_sum_raw < -((ERR_W+1)'(SUM_LIMIT))) begin
            w_sum = -SUM_LIMIT;
        end else begin
            w_sum = w_sum_raw[SUM_W-1:0];
        end
    end

    assign w_inner = {{(WIDE_W - ERR_W){r_e[ERR_W-1]}}, r_e} + r_ip + signed_q(w_q, r_neg_d);

    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            S_I_LO, S_D_LO, S_K_LO:    w_ctl.lo  = 1'b1;
            S_I_HI, S_D_HI, S_K_HI:    w_ctl.hi  = 1'b1;
            S_I_ADD, S_D_ADD, S_K_ADD: w_ctl.add = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_I_LO, S_I_HI, S_I_ADD: w_gain = w_gains.ki;
            S_D_LO, S_D_HI, S_D_ADD: w_gain = w_gains.kd;
            default:                 w_gain = w_gains.kp;
        endcase
    end

    // Saturate the final magnitude, then restore the sign.
    always_comb begin
        if (r_neg_k) begin
            w_sat_mag = (w_q > OUT_NEG_MAX) ? OUT_NEG_MAX[ERR_W-1:0] : w_q[ERR_W-1:0];
            w_drive   = -w_sat_mag;
        end else begin
            w_sat_mag = (w_q > OUT_POS_MAX) ? OUT_POS_MAX[ERR_W-1:0] : w_q[ERR_W-1:0];
            w_drive   = w_sat_mag;
        end
    end

    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept && i_in.command == CMD_UPDATE) n_state = S_I_LO;
            S_I_LO:  n_state = S_I_HI;
            S_I_HI:  n_state = S_I_ADD;
            S_I_ADD: n_state = S_D_LO;
            S_D_LO:  n_state = S_D_HI;
            S_D_HI:  n_state = S_D_ADD;
            S_D_ADD: n_state = S_INNER;
            S_INNER: n_state = S_ABS;
            S_ABS:   n_state = S_K_LO;
            S_K_LO:  n_state = S_K_HI;
            S_K_HI:  n_state = S_K_ADD;
            S_K_ADD: n_state = S_OUT;
            S_OUT:   if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err_sum   <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                if (i_in.command == CMD_CLEAR) begin
                    r_err_sum <= '0;
                    r_prev    <= '0;
                end else begin
                    r_err_sum <= w_sum;
                    r_prev    <= w_e;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e     <= w_e;
            r_diff  <= {w_e[ERR_W-1], w_e} - {r_prev[ERR_W-1], r_prev};
            r_mag   <= mag_of(WIDE_W'(w_sum));
            r_neg_i <= w_sum[SUM_W-1];
        end
        unique case (r_state)
            S_I_ADD: begin
                r_mag   <= mag_of(WIDE_W'(r_diff));
                r_neg_d <= r_diff[DIFF_W-1];
            end
            S_D_LO:  r_ip <= signed_q(w_q, r_neg_i);
            S_INNER: r_inner <= w_inner;
            S_ABS: begin
                r_mag   <= mag_of(r_inner);
                r_neg_k <= r_inner[WIDE_W-1];
            end
            default: ;
        endcase
        if (w_load_out) begin
            r_drive <= w_drive;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.drive_value = r_drive;

endmodule

FILE: rtl/prc_checker.sv
// Port-level checks for the PID rate controller, bound to the top level.
// Depends on prc_pkg and pid_rate_controller.
module prc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_command,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [prc_pkg::ERR_W-1:0]   i_drive_value,
    input logic                        i_pready
);
    import prc_pkg::*;

    // An update item keeps the input closed while the multiplier works on it.
    a_busy_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_command == CMD_UPDATE) |=> ##1 !i_in_ready)
        else $error("input ready too soon after an update item");

    // A clear item never produces a result of its own.
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_command == CMD_CLEAR && !i_out_valid)
        |=> !i_out_valid)
        else $error("result appeared after a clear item");

    // A waiting result holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_drive_value)))
        else $error("pending result changed or dropped");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("configuration port not ready");

endmodule

bind pid_rate_controller prc_checker u_prc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_command  (i_in.command),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_drive_value (o_out.drive_value),
    .i_pready      (pready)
);

FILE: sim/pid_rate_controller_test.sv
// Self-checking testbench for pid_rate_controller: update and clear items,
// APB gain writes with read-back, random stalls on both channels.
// Depends on prc_pkg, prc_if and the controller RTL.
module pid_rate_controller_test;
    timeunit 1ns;
    timeprecision 1ps;
    import prc_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          LONG_HOLD     = 500;
    localparam int          PHASES        = 10;
    localparam int          PHASE_ITEMS   = 155;
    localparam int          PROBE_ROWS    = 23;
    localparam logic [31:0] KP_ONE        = 32'h0100_0000;
    localparam logic [31:0] GAIN_MAX      = 32'hFFFF_FFFF;
    localparam logic [31:0] ERR_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] ERR_MIN       = 32'h8000_0000;

    typedef struct packed {
        logic              load;
        t_gains            gains;
        logic              command;
        logic [ERR_W-1:0]  error_value;
        logic              typed;
        logic [ERR_W-1:0]  drive_value;
    } t_probe_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    prc_in_if  in_ch();
    prc_out_if out_ch();

    pid_rate_controller u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state, kept in step with the items the block accepts.
    t_gains                   loop_gains     = '0;
    logic signed [SUM_W-1:0]  integral_acc   = '0;
    logic signed [ERR_W-1:0]  last_error     = '0;
    logic [ERR_W-1:0]         drive_expected_q[$];

    int  fault_count    = 0;
    int  cycle_count    = 0;
    int  updates_sent   = 0;
    int  clears_sent    = 0;
    int  drives_checked = 0;
    int  gain_settings  = 0;
    bit  calm           = 1'b0;
    bit  hold_request   = 1'b0;

    t_probe_row probe_rows [PROBE_ROWS] = '{
        '{1'b0, '0, CMD_UPDATE, ERR_MAX, 1'b1, 32'd0},
        '{1'b0, '0, CMD_UPDATE, ERR_MIN, 1'b1, 32'd0},
        '{1'b0, '0, CMD_CLEAR, 32'd0, 1'b0, 32'd0},
        '{1'b1, '{KP_ONE, 32'd0, 32'd0}, CMD_UPDATE, 32'h0001_0000, 1'b1, 32'h0001_0000},
        '{1'b0, '0, CMD_UPDATE, ERR_MIN, 1'b1, ERR_MIN},
        '{1'b0, '0, CMD_UPDATE, ERR_MAX, 1'b1, ERR_MAX},
        '{1'b0, '0, CMD_CLEAR, 32'd0, 1'b0, 32'd0},
        '{1'b1, '{GAIN_MAX, 32'd0, 32'd0}, CMD_UPDATE, ERR_MAX, 1'b1, ERR_MAX},
        '{1'b0, '0, CMD_UPDATE, ERR_MIN, 1'b1, ERR_MIN},
        '{1'b0, '0, CMD_UPDATE, 32'd0, 1'b1, 32'd0},
        '{1'b1, '{KP_ONE, KP_ONE, 32'd0}, CMD_UPDATE, ERR_MAX, 1'b0, 32'd0},
        '{1'b0, '0, CMD_UPDATE, ERR_MIN, 1'b0, 32'd0},
        '{1'b0, '0, CMD_UPDATE, ERR_MIN, 1'b0, 32'd0},
        '{1'b0, '0, CMD_CLEAR, 32'd0, 1'b0, 32'd0},
        '{1'b0, '0, CMD_UPDATE, 32'h0064_0000, 1'b0, 32'd0},
        '{1'b1, '{KP_ONE, 32'd0, GAIN_MAX}, CMD_UPDATE, ERR_MAX, 1'b0, 32'd0},
        '{1'b0, '0, CMD_UPDATE, ERR_MIN, 1'b0, 32'd0},
        '{1'b0, '0, CMD_UPDATE, ERR_MAX, 1'b0, 32'd0},
        '{1'b1, '{32'h0080_0000, 32'h0010_0000, 32'h0200_0000}, CMD_UPDATE,
          32'hFFFF_0000, 1'b0, 32'd0},
        '{1'b0, '0, CMD_UPDATE, 32'h0001_8000, 1'b0, 32'd0},
        '{1'b0, '0, CMD_CLEAR, 32'd0, 1'b0, 32'd0},
        '{1'b0, '0, CMD_UPDATE, 32'd1, 1'b0, 32'd0},
        '{1'b0, '0, CMD_UPDATE, 32'hFFFF_FFFF, 1'b0, 32'd0}
    };

    // Exact floor of magnitude times Q8.24 gain, magnitude below 2^42.
    function automatic logic [63:0] scale_q24(logic [63:0] mag, logic [GAIN_W-1:0] gain);
        logic [95:0] full;
        full = {32'd0, mag} * {64'd0, gain};
        return full[87:24];
    endfunction

    // Gain product truncated toward zero: scale the magnitude, restore the sign.
    function automatic longint apply_gain(longint v, logic [GAIN_W-1:0] gain);
        if (v < 0)
            return -$signed(scale_q24(-v, gain));
        return $signed(scale_q24(v, gain));
    endfunction

    function automatic logic [ERR_W-1:0] predict_drive(logic signed [ERR_W-1:0] e);
        longint      sum;
        longint      diff;
        longint      inner;
        logic [63:0] prod;
        sum = longint'(integral_acc) + longint'(e);
        if (sum > longint'(SUM_LIMIT))
            sum = longint'(SUM_LIMIT);
        if (sum < -longint'(SUM_LIMIT))
            sum = -longint'(SUM_LIMIT);
        integral_acc = SUM_W'(sum);
        diff = longint'(e) - longint'(last_error);
        last_error = e;
        inner = longint'(e) + apply_gain(sum, loop_gains.ki) + apply_gain(diff, loop_gains.kd);
        if (inner < 0) begin
            prod = scale_q24(-inner, loop_gains.kp);
            if (prod > 64'h8000_0000)
                prod = 64'h8000_0000;
            prod = -prod;
        end else begin
            prod = scale_q24(inner, loop_gains.kp);
            if (prod > 64'h7FFF_FFFF)
                prod = 64'h7FFF_FFFF;
        end
        return prod[ERR_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return GAIN_MAX;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    task automatic apb_transfer(input logic wr, input logic [1:0] reg_id,
                                input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = ADDR_W'({reg_id, 2'b00});
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_gain(input logic [1:0] reg_id, input logic [GAIN_W-1:0] value);
        logic [DATA_W-1:0] rdata;
        apb_transfer(1'b1, reg_id, value, rdata);
        case (reg_id)
            REG_KP: loop_gains.kp = value;
            REG_KI: loop_gains.ki = value;
            default: loop_gains.kd = value;
        endcase
        apb_transfer(1'b0, reg_id, '0, rdata);
        if (rdata !== value) begin
            $display("%0t: gain register %0d read back: expected %h, got %h",
                     $time, reg_id, value, rdata);
            fault_count++;
        end
    endtask

    task automatic set_gains(input t_gains g);
        write_gain(REG_KP, g.kp);
        write_gain(REG_KI, g.ki);
        write_gain(REG_KD, g.kd);
        gain_settings++;
    endtask

    // Lower valid and let the block run dry, so that gains change only while idle.
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (drive_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(input logic command, input logic [ERR_W-1:0] error_value,
                             input logic typed, input logic [ERR_W-1:0] typed_drive);
        logic [ERR_W-1:0] predicted;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.command     = command;
        in_ch.error_value = error_value;
        do @(posedge i_clk); while (!in_ch.ready);
        if (command == CMD_CLEAR) begin
            integral_acc = '0;
            last_error   = '0;
            clears_sent++;
        end else begin
            predicted = predict_drive(error_value);
            drive_expected_q.push_back(typed ? typed_drive : predicted);
            updates_sent++;
        end
    endtask

    initial begin : stimulus
        t_gains           g;
        logic             command;
        logic [ERR_W-1:0] error_value;
        logic [31:0]      r;
        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_UPDATE;
        in_ch.error_value = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        i_rst_n           = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < PROBE_ROWS; i++) begin
            if (probe_rows[i].load) begin
                wait_drained();
                set_gains(probe_rows[i].gains);
            end
            send_item(probe_rows[i].command, probe_rows[i].error_value,
                      probe_rows[i].typed, probe_rows[i].drive_value);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: g = '{GAIN_MAX, GAIN_MAX, GAIN_MAX};
                1: g = '0;
                2: g = '{KP_ONE, 32'h0001_0000, 32'h0020_0000};
                default: g = '{random_gain(), random_gain(), random_gain()};
            endcase
            set_gains(g);
            calm = (phase == PHASES - 1);
            // The receiver stalls for a long stretch while items keep coming.
            if (phase == 3)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                command = ($urandom_range(0, 11) == 0) ? CMD_CLEAR : CMD_UPDATE;
                r = $urandom;
                case ($urandom_range(0, 5))
                    0: error_value = r;
                    1: case (r[1:0])
                        2'd0: error_value = ERR_MAX;
                        2'd1: error_value = ERR_MIN;
                        2'd2: error_value = '0;
                        default: error_value = 32'hFFFF_FFFF;
                    endcase
                    2, 3: error_value = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
                    default: error_value = {{8{r[23]}}, r[23:0]};
                endcase
                send_item(command, error_value, 1'b0, '0);
            end
        end

        wait_drained();
        $display("Covered %0d updates and %0d clears over %0d gain settings; %0d drive values checked.",
                 updates_sent, clears_sent, gain_settings, drives_checked);
        $display("Both channels stalled at random, with one long output hold and full drains.");
        if (fault_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : receiver
        int  stall_left;
        int  hold_left;
        bit  hold_taken;
        stall_left   = 0;
        hold_left    = 0;
        hold_taken   = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left   = $urandom_range(1, 13) - 1;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (drive_expected_q.size() == 0) begin
                $display("%0t: drive value %h arrived with none expected",
                         $time, out_ch.drive_value);
                fault_count++;
            end else begin
                if (out_ch.drive_value !== drive_expected_q[0]) begin
                    $display("%0t: drive value mismatch: expected %h, got %h",
                             $time, drive_expected_q[0], out_ch.drive_value);
                    fault_count++;
                end
                void'(drive_expected_q.pop_front());
                drives_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d drive values outstanding.",
                     cycle_count, drive_expected_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
